// ===== rtl/gepc_pkg.sv =====
package gepc_pkg;

	localparam int unsigned DEF_MAX_ROWS  = 64;
	localparam int unsigned DEF_MAX_COLS  = 64;
	localparam int unsigned DEF_MAX_MOVES = 64;

	localparam logic [29:0] PATH_MOD = 30'd1000000007;
	localparam int unsigned NUM_DIR   = 4;
	localparam int unsigned CMP_W     = 9;
	localparam int unsigned DRAIN_CYC = 4;

	typedef struct packed {
		logic [6:0] grid_rows;
		logic [6:0] grid_cols;
		logic [6:0] move_budget;
		logic [5:0] start_row;
		logic [5:0] start_col;
	} req_t;

	typedef struct packed {
		logic [29:0] path_count;
		logic        bad_request;
	} rsp_t;

	// Sum of two reduced counts, reduced again.
	function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
		logic [30:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, PATH_MOD}) begin
			s = s - {1'b0, PATH_MOD};
		end
		return s[29:0];
	endfunction

endpackage

// ===== rtl/grid_exit_path_counter.sv =====
// Answers: a start cell outside the grid or a zero move budget is answered at intake;
//   otherwise one sweep per move of the budget runs before the result is offered.
// Throughput: one request at a time; each sweep updates one cell per cycle through
//   the read, pairwise-sum and cell-total stages and drains them before the next sweep reads.
// Reset: arst_n clears control and the result valid flag; the count stores are not
//   cleared, since the first sweep of a request treats all previous counts as zero.
module grid_exit_path_counter #(
	parameter int unsigned MAX_ROWS  = gepc_pkg::DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS  = gepc_pkg::DEF_MAX_COLS,
	parameter int unsigned MAX_MOVES = gepc_pkg::DEF_MAX_MOVES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  gepc_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output gepc_pkg::rsp_t   rsp
);
	import gepc_pkg::*;

	localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned AW    = 1 + RW + CW;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned DW    = (DRAIN_CYC > 1) ? $clog2(DRAIN_CYC) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_DONE} state_t;

	state_t          state_q;
	logic [6:0]      rows_q, cols_q, budget_q, k_q;
	logic [RW-1:0]   r_q, sr_q;
	logic [CW-1:0]   c_q, sc_q;
	logic [DW-1:0]   drain_q;
	logic            prev_sel_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	logic [29:0]     res_q;

	// saturated request fields
	logic [6:0]      rows_sat, cols_sat, budget_sat;
	logic            start_out;
	logic            req_fire, rsp_free, rsp_load;
	logic            last_col, last_row, issue;

	// pipeline
	logic [AW-1:0]   raddr [NUM_DIR];
	logic [NUM_DIR-1:0] out_nb;
	logic [29:0]     mem_q [NUM_DIR][DEPTH];
	logic [29:0]     rd_s1 [NUM_DIR];
	logic [NUM_DIR-1:0] out_s1;
	logic            v_s1, v_s2, v_s3;
	logic            first_s1;
	logic            hit_s1, hit_s2, hit_s3;
	logic [AW-1:0]   waddr_s1, waddr_s2, waddr_s3;
	logic [29:0]     term [NUM_DIR];
	logic [29:0]     sum01_s2, sum23_s2, acc_s3;

	assign rows_sat   = (CMP_W'(req.grid_rows) > CMP_W'(MAX_ROWS)) ? 7'(MAX_ROWS) : req.grid_rows;
	assign cols_sat   = (CMP_W'(req.grid_cols) > CMP_W'(MAX_COLS)) ? 7'(MAX_COLS) : req.grid_cols;
	assign budget_sat = (11'(req.move_budget) > 11'(MAX_MOVES)) ? 7'(MAX_MOVES)
		: req.move_budget;
	assign start_out  = (CMP_W'(req.start_row) >= CMP_W'(rows_sat))
		|| (CMP_W'(req.start_col) >= CMP_W'(cols_sat));

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && rsp_free;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// load a new result item: an immediate answer at intake or the sweep total
	assign rsp_load = (req_fire && (start_out || (budget_sat == '0)))
		|| ((state_q == ST_DONE) && rsp_free);

	assign issue    = (state_q == ST_SWEEP);
	assign last_col = (CMP_W'(c_q) + CMP_W'(1)) == CMP_W'(cols_q);
	assign last_row = (CMP_W'(r_q) + CMP_W'(1)) == CMP_W'(rows_q);

	// Neighbor flags and addresses in the previous bank: right, up, left, down.
	always_comb begin
		out_nb[0] = last_col;
		out_nb[1] = (r_q == '0);
		out_nb[2] = (c_q == '0);
		out_nb[3] = last_row;
		raddr[0]  = {prev_sel_q, r_q, CW'(c_q + 1'b1)};
		raddr[1]  = {prev_sel_q, RW'(r_q - 1'b1), c_q};
		raddr[2]  = {prev_sel_q, r_q, CW'(c_q - 1'b1)};
		raddr[3]  = {prev_sel_q, RW'(r_q + 1'b1), c_q};
	end

	// Sequencer: request intake, cell scan, sweep drain and result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			prev_sel_q  <= 1'b0;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			drain_q     <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						rows_q   <= rows_sat;
						cols_q   <= cols_sat;
						budget_q <= budget_sat;
						sr_q     <= RW'(req.start_row);
						sc_q     <= CW'(req.start_col);
						r_q      <= '0;
						c_q      <= '0;
						k_q      <= '0;
						if (start_out) begin
							// answer at once: flag the bad start cell
							rsp_q <= '{path_count: '0, bad_request: 1'b1};
						end else if (budget_sat == '0) begin
							rsp_q <= '{path_count: '0, bad_request: 1'b0};
						end else begin
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					// advance the raster scan one cell
					if (last_col) begin
						c_q <= '0;
						if (last_row) begin
							r_q     <= '0;
							drain_q <= '0;
							state_q <= ST_DRAIN;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// hold until the last writes of the sweep land
					if (drain_q == DW'(DRAIN_CYC - 1)) begin
						prev_sel_q <= ~prev_sel_q;
						if (k_q + 1'b1 == budget_q) begin
							state_q <= ST_DONE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_SWEEP;
						end
					end else begin
						drain_q <= drain_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_q   <= '{path_count: res_q, bad_request: 1'b0};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Stage 1: registered reads of the four neighbors, one store copy each.
	always_ff @(posedge clk) begin
		for (int d = 0; d < NUM_DIR; d++) begin
			rd_s1[d] <= mem_q[d][raddr[d]];
		end
		if (v_s3) begin
			for (int d = 0; d < NUM_DIR; d++) begin
				mem_q[d][waddr_s3] <= acc_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		for (int d = 0; d < NUM_DIR; d++) begin
			if (out_s1[d]) begin
				term[d] = 30'd1;
			end else if (first_s1) begin
				term[d] = '0;
			end else begin
				term[d] = rd_s1[d];
			end
		end
	end

	always_ff @(posedge clk) begin
		out_s1   <= out_nb;
		first_s1 <= (k_q == '0);
		hit_s1   <= (k_q + 1'b1 == budget_q) && (r_q == sr_q) && (c_q == sc_q);
		waddr_s1 <= {~prev_sel_q, r_q, c_q};
		// Stage 2: pairwise sums
		sum01_s2 <= add_mod(term[0], term[1]);
		sum23_s2 <= add_mod(term[2], term[3]);
		hit_s2   <= hit_s1;
		waddr_s2 <= waddr_s1;
		// Stage 3: cell total, written next edge
		acc_s3   <= add_mod(sum01_s2, sum23_s2);
		hit_s3   <= hit_s2;
		waddr_s3 <= waddr_s2;
		if (v_s3 && hit_s3) begin
			res_q <= acc_s3;
		end
	end

endmodule

// ===== rtl/gepc_checker.sv =====
module gepc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input gepc_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input gepc_pkg::rsp_t rsp
);
	import gepc_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.path_count < PATH_MOD)
		else $error("path count not reduced");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_request |-> rsp.path_count == '0)
		else $error("bad request with nonzero count");

	a_bad_fast: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && ((req.start_row >= 6'(req.grid_rows) && req.grid_rows < 7'd64)
		|| (req.start_col >= 6'(req.grid_cols) && req.grid_cols < 7'd64)
		|| req.grid_rows == '0 || req.grid_cols == '0)
		|=> rsp_valid && rsp.bad_request)
		else $error("start outside grid not flagged");

endmodule

bind grid_exit_path_counter gepc_checker u_gepc_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready), .req(req),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);

// ===== dv/tb_grid_exit_path_counter.sv =====
module tb_grid_exit_path_counter;
	import gepc_pkg::*;

	localparam int unsigned GRID_ROWS    = 64;
	localparam int unsigned GRID_COLS    = 64;
	localparam int unsigned MOVE_LIMIT   = 64;
	localparam int unsigned IDLE_LIMIT   = 1500000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned RANDOM_ITEMS = 85;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Expected results, oldest first.
	rsp_t exp_rsp_q[$];
	int unsigned fail_cnt = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left;
	bit hold_rsp;
	bit no_gaps;

	// Ping-pong count grids of the predictor.
	logic [29:0] sweep_prev[GRID_ROWS*GRID_COLS];
	logic [29:0] sweep_next[GRID_ROWS*GRID_COLS];

	grid_exit_path_counter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [29:0] mod_sum(input logic [29:0] a, input logic [29:0] b);
		logic [30:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 31'd1000000007) begin
			s = s - 31'd1000000007;
		end
		return s[29:0];
	endfunction

	// Count exiting paths: one sweep per move over the grid in use.
	function rsp_t count_exit_paths(input req_t r);
		rsp_t res;
		int rows, cols, moves, nr, nc;
		logic [29:0] acc;
		rows  = (r.grid_rows > GRID_ROWS) ? GRID_ROWS : r.grid_rows;
		cols  = (r.grid_cols > GRID_COLS) ? GRID_COLS : r.grid_cols;
		moves = (r.move_budget > MOVE_LIMIT) ? MOVE_LIMIT : r.move_budget;
		res = '0;
		// A start outside the grid wins over a zero budget.
		if (r.start_row >= rows || r.start_col >= cols) begin
			res.bad_request = 1'b1;
			return res;
		end
		if (moves == 0) begin
			return res;
		end
		foreach (sweep_prev[i]) sweep_prev[i] = '0;
		for (int k = 0; k < moves; k++) begin
			for (int y = 0; y < rows; y++) begin
				for (int x = 0; x < cols; x++) begin
					acc = '0;
					for (int d = 0; d < 4; d++) begin
						nr = y + ((d == 1) ? -1 : (d == 3) ? 1 : 0);
						nc = x + ((d == 0) ? 1 : (d == 2) ? -1 : 0);
						if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) begin
							acc = mod_sum(acc, 30'd1);
						end else begin
							acc = mod_sum(acc, sweep_prev[nr*GRID_COLS + nc]);
						end
					end
					sweep_next[y*GRID_COLS + x] = acc;
				end
			end
			sweep_prev = sweep_next;
		end
		res.path_count = sweep_prev[r.start_row*GRID_COLS + r.start_col];
		return res;
	endfunction

	// Offer one item, hold it until accepted, then queue its expected result.
	// Between bursts drop valid for a random gap.
	task automatic send_request(input req_t r);
		int unsigned gap;
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		exp_rsp_q.push_back(count_exit_paths(r));
		if (!no_gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(0, 5);
			end else begin
				burst_left--;
			end
		end
	endtask

	function automatic req_t make_req(input int gr, gc, mb, sr, sc);
		req_t r;
		r.grid_rows   = gr[6:0];
		r.grid_cols   = gc[6:0];
		r.move_budget = mb[6:0];
		r.start_row   = sr[5:0];
		r.start_col   = sc[5:0];
		return r;
	endfunction

	// Receiver: random stalls, stretches of always-ready, and on request one long hold-off.
	initial begin
		int unsigned stretch;
		bit steady;
		rsp_ready = 1'b0;
		stretch   = 0;
		steady    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				if (stretch == 0) begin
					steady  = ($urandom_range(0, 2) == 0);
					stretch = $urandom_range(5, 40);
				end
				stretch--;
				rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (exp_rsp_q.size() == 0) begin
				$error("unexpected result: path_count %0d bad_request %0b",
					rsp.path_count, rsp.bad_request);
				fail_cnt++;
			end else begin
				e = exp_rsp_q.pop_front();
				if (rsp.path_count !== e.path_count) begin
					$error("path_count: expected %0d, actual %0d", e.path_count, rsp.path_count);
					fail_cnt++;
				end
				if (rsp.bad_request !== e.bad_request) begin
					$error("bad_request: expected %0b, actual %0b", e.bad_request,
						rsp.bad_request);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog: end the run after too long without any handshake.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** grid_exit_path_counter: FAILED **");
			$finish;
		end
	end

	task automatic test_bad_start();
		send_request(make_req(0, 5, 3, 0, 0));    // zero rows
		send_request(make_req(5, 0, 3, 0, 0));    // zero columns
		send_request(make_req(4, 4, 0, 4, 1));    // outside, zero budget too
		send_request(make_req(4, 4, 5, 1, 4));
		send_request(make_req(127, 127, 2, 63, 63));
		send_request(make_req(3, 64, 1, 63, 2));
	endtask

	task automatic test_zero_budget();
		send_request(make_req(1, 1, 0, 0, 0));
		send_request(make_req(64, 64, 0, 63, 63));
	endtask

	task automatic test_extremes();
		send_request(make_req(1, 1, 1, 0, 0));
		send_request(make_req(1, 1, 127, 0, 0));   // budget saturates
		send_request(make_req(1, 64, 3, 0, 63));
		send_request(make_req(64, 1, 2, 63, 0));
		send_request(make_req(127, 100, 1, 63, 63)); // grid saturates
		send_request(make_req(2, 2, 2, 1, 1));
		send_request(make_req(3, 3, 64, 1, 1));     // counts wrap the modulus
		send_request(make_req(5, 7, 96, 2, 6));
		send_request(make_req(64, 64, 64, 32, 31)); // largest request
	endtask

	task automatic test_backpressure();
		no_gaps  = 1'b1;
		hold_rsp = 1'b1;
		for (int i = 0; i < 4; i++) begin
			send_request(make_req($urandom_range(1, 6), $urandom_range(1, 6),
				$urandom_range(0, 4), $urandom_range(0, 5), $urandom_range(0, 5)));
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_random();
		req_t r;
		int gr, gc;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				// Mostly small requests with a start inside the grid, now and then a random start column.
				gr = $urandom_range(1, 10);
				gc = $urandom_range(1, 10);
				r = make_req(gr, gc, $urandom_range(0, 14),
					$urandom_range(0, gr - 1), $urandom_range(0, gc - 1));
				if ($urandom_range(0, 9) == 0) begin
					r.start_col = 6'($urandom_range(0, 63));
				end
			end else begin
				// Any field value; keep the budget short so big grids stay cheap.
				r = make_req($urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
			end
			send_request(r);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		burst_left  = 0;
		hold_rsp    = 1'b0;
		no_gaps     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bad_start();
		test_zero_budget();
		test_extremes();
		test_backpressure();
		test_random();

		req_valid <= 1'b0;
		wait (exp_rsp_q.size() == 0);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("** grid_exit_path_counter: PASSED **");
		end else begin
			$display("** grid_exit_path_counter: FAILED **");
		end
		$finish;
	end

endmodule

// ===== grid_exit_path_counter.f =====
rtl/gepc_pkg.sv
rtl/grid_exit_path_counter.sv
rtl/gepc_checker.sv
dv/tb_grid_exit_path_counter.sv
